@@ sv/stbs_pkg.sv @@
// ----------------------------------------------------------------------------
// Sorted table binary search package
// Shared constants, operation codes and the search sequencer state type.
// ----------------------------------------------------------------------------
package stbs_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 512;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);

  // Field widths fixed by the interface
  localparam int FUNC_W  = 1;
  localparam int INDEX_W = 9;
  localparam int VALUE_W = 32;
  localparam int POS_W   = 9;
  localparam int COUNT_W = 10;

  // Signed search window bounds: room for -1 and for TABLE_DEPTH
  localparam int WIN_W = ADDR_W + 2;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_LOAD   = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_DONE
  } state_t;

endpackage

@@ sv/stbs_req_if.sv @@
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one load or search item.
// ----------------------------------------------------------------------------
interface stbs_req_if;
  logic                                    valid;
  logic                                    ready;
  logic        [stbs_pkg::FUNC_W-1:0]      func;
  logic        [stbs_pkg::INDEX_W-1:0]     index;
  logic signed [stbs_pkg::VALUE_W-1:0]     value;

  modport source (output valid, output func, output index, output value, input ready);
  modport sink   (input valid, input func, input index, input value, output ready);
endinterface

@@ sv/stbs_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one search result item.
// ----------------------------------------------------------------------------
interface stbs_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic [stbs_pkg::POS_W-1:0]    position;

  modport source (output valid, output found, output position, input ready);
  modport sink   (input valid, input found, input position, output ready);
endinterface

@@ sv/stbs_table.sv @@
// ----------------------------------------------------------------------------
// Code table
// Single-port-write, single-port-read memory with registered read data.
// ----------------------------------------------------------------------------
module stbs_table (
  input  logic                                clk,
  input  logic                                we,
  input  logic        [stbs_pkg::ADDR_W-1:0]  waddr,
  input  logic signed [stbs_pkg::VALUE_W-1:0] wdata,
  input  logic        [stbs_pkg::ADDR_W-1:0]  raddr,
  output logic signed [stbs_pkg::VALUE_W-1:0] rdata
);

  logic signed [stbs_pkg::VALUE_W-1:0] mem [stbs_pkg::TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ sv/sorted_table_binary_search.sv @@
// ----------------------------------------------------------------------------
// Sorted table binary search
// Holds a table of signed codes in ascending order; load items write one
// entry, search items run a binary search over the first entry_count entries.
// ----------------------------------------------------------------------------
// Load: written when taken, no result; the next item is taken in the next cycle.
// Search: one cycle per probe (one table read per cycle, compare and next
//   midpoint in the same cycle), at most log2(depth)+1 = 10 probes; then
//   S_DONE waits for a free output register, loads it and returns to idle.
// Reset (rst, synchronous): sequencer idle, output empty, entry_count = 0;
//   table contents are not cleared and are undefined until loaded.
module sorted_table_binary_search (
  input  logic                                 clk,
  input  logic                                 rst,
  stbs_req_if.sink                             req,
  stbs_rsp_if.source                           rsp,
  input  logic                                 cfg_we,
  input  logic [stbs_pkg::COUNT_W-1:0]         cfg_wdata
);

  localparam int AW = stbs_pkg::ADDR_W;
  localparam int WW = stbs_pkg::WIN_W;
  localparam int VW = stbs_pkg::VALUE_W;
  localparam int CW = stbs_pkg::COUNT_W;
  localparam int PW = stbs_pkg::POS_W;

  // --------------------------------------------------------------------------
  // Configuration: number of sorted entries, saturated at the table depth
  // --------------------------------------------------------------------------
  logic [CW-1:0] entry_count;
  logic [CW-1:0] active_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_we) begin
      entry_count <= cfg_wdata;
    end
  end

  assign active_count = (entry_count > CW'(stbs_pkg::TABLE_DEPTH)) ?
                        CW'(stbs_pkg::TABLE_DEPTH) : entry_count;

  // --------------------------------------------------------------------------
  // Sequencer registers
  // --------------------------------------------------------------------------
  stbs_pkg::state_t state, state_next;

  logic signed [WW-1:0] low, low_next;      // inclusive window bounds
  logic signed [WW-1:0] high, high_next;
  logic        [AW-1:0] mid, mid_next;      // entry under probe
  logic signed [VW-1:0] key, key_next;
  logic                 hit, hit_next;

  // Output register
  logic          out_valid;
  logic          out_found;
  logic [PW-1:0] out_pos;
  logic          res_load;

  // Table ports
  logic                 tbl_we;
  logic        [AW-1:0] tbl_raddr;
  logic signed [VW-1:0] tbl_rdata;

  // Shared window arithmetic: candidate bounds and their midpoint
  logic signed [WW-1:0] cand_low;
  logic signed [WW-1:0] cand_high;
  logic signed [WW-1:0] span;
  logic signed [WW-1:0] mid_calc;
  logic signed [WW-1:0] mid_ext;

  logic req_fire;

  assign req_fire  = req.valid && req.ready;
  assign req.ready = (state == stbs_pkg::S_IDLE);

  // Loads beyond the table depth are dropped
  assign tbl_we = req_fire && (req.func == stbs_pkg::FUNC_LOAD) &&
                  ({1'b0, req.index} < (stbs_pkg::INDEX_W + 1)'(stbs_pkg::TABLE_DEPTH));

  stbs_table u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (req.index[AW-1:0]),
    .wdata (req.value),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stbs_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    low  <= low_next;
    high <= high_next;
    mid  <= mid_next;
    key  <= key_next;
    hit  <= hit_next;
  end

  assign mid_ext = WW'(mid);

  // --------------------------------------------------------------------------
  // Next state, window update and read address
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    low_next   = low;
    high_next  = high;
    mid_next   = mid;
    key_next   = key;
    hit_next   = hit;
    res_load   = 1'b0;
    cand_low   = low;
    cand_high  = high;

    unique case (state)
      stbs_pkg::S_IDLE: begin
        // Open the window over the whole active range
        cand_low  = '0;
        cand_high = WW'(active_count) - WW'(1);
      end
      stbs_pkg::S_PROBE: begin
        // Halve the window around the entry just read
        if (tbl_rdata > key) begin
          cand_high = mid_ext - WW'(1);
        end else begin
          cand_low = mid_ext + WW'(1);
        end
      end
      stbs_pkg::S_DONE: begin
      end
      default: begin
      end
    endcase

    span      = cand_high - cand_low;
    mid_calc  = cand_low + (span >>> 1);
    tbl_raddr = mid_calc[AW-1:0];

    unique case (state)
      stbs_pkg::S_IDLE: begin
        if (req_fire && (req.func == stbs_pkg::FUNC_SEARCH)) begin
          key_next  = req.value;
          hit_next  = 1'b0;
          low_next  = cand_low;
          high_next = cand_high;
          mid_next  = mid_calc[AW-1:0];
          if (cand_high < cand_low) begin
            state_next = stbs_pkg::S_DONE;
          end else begin
            state_next = stbs_pkg::S_PROBE;
          end
        end
      end
      stbs_pkg::S_PROBE: begin
        if (tbl_rdata == key) begin
          // Match: hold mid as the reported position
          hit_next   = 1'b1;
          state_next = stbs_pkg::S_DONE;
        end else if (cand_high < cand_low) begin
          hit_next   = 1'b0;
          state_next = stbs_pkg::S_DONE;
        end else begin
          low_next  = cand_low;
          high_next = cand_high;
          mid_next  = mid_calc[AW-1:0];
        end
      end
      stbs_pkg::S_DONE: begin
        // Advance once the output register is free or being drained
        if (!out_valid || rsp.ready) begin
          res_load   = 1'b1;
          state_next = stbs_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = stbs_pkg::S_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Output register: holds the result item until taken
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_found <= hit;
      out_pos   <= hit ? PW'(mid) : '0;
    end
  end

  assign rsp.valid    = out_valid;
  assign rsp.found    = out_found;
  assign rsp.position = out_pos;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef SYNTHESIS
  // The probed entry always lies inside the current window
  a_mid_in_window: assert property (@(posedge clk) disable iff (rst)
    (state == stbs_pkg::S_PROBE) |-> (mid_ext >= low && mid_ext <= high))
    else $error("probe outside search window");

  // A not-found result always reports position zero
  a_miss_pos_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_found) |-> (out_pos == '0))
    else $error("miss result with nonzero position");

  // An accepted search always leaves the idle state
  a_search_starts: assert property (@(posedge clk) disable iff (rst)
    (req_fire && req.func == stbs_pkg::FUNC_SEARCH) |=> (state != stbs_pkg::S_IDLE))
    else $error("search item accepted without starting");

  // A result is loaded only when the output slot is free or draining
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_load |-> (!out_valid || rsp.ready))
    else $error("pending result overwritten");
`endif

endmodule

@@ dv/search_checker.sv @@
// ----------------------------------------------------------------------------
// Search result checker
// Watches the request, response and register ports of the sorted table
// search block, keeps its own copy of the table and entry count, predicts
// each search outcome and compares every result item in order.
// ----------------------------------------------------------------------------
module search_checker (
  input  logic                          clk,
  input  logic                          rst,
  stbs_req_if                           req,
  stbs_rsp_if                           rsp,
  input  logic                          cfg_we,
  input  logic [stbs_pkg::COUNT_W-1:0]  cfg_wdata,
  output int                            mismatches,
  output int                            outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH;
  localparam int ADDR_W      = stbs_pkg::ADDR_W;
  localparam int VALUE_W     = stbs_pkg::VALUE_W;
  localparam int POS_W       = stbs_pkg::POS_W;
  localparam int COUNT_W     = stbs_pkg::COUNT_W;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } search_result_t;

  logic signed [VALUE_W-1:0] code_mem [TABLE_DEPTH];
  logic [COUNT_W-1:0]        entry_count_q = '0;
  search_result_t            expected_hits [$];
  int                        mismatch_count = 0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    mismatch_count++;
  endtask

  // Probe at the window midpoint until a hit or an empty window.
  function automatic search_result_t predict_search(input logic signed [VALUE_W-1:0] key);
    int             lo;
    int             hi;
    int             mid;
    search_result_t res;
    res = '0;
    lo  = 0;
    hi  = (entry_count_q > TABLE_DEPTH ? TABLE_DEPTH : int'(entry_count_q)) - 1;
    while (hi >= lo) begin
      mid = lo + (hi - lo) / 2;
      if (code_mem[mid[ADDR_W-1:0]] == key) begin
        res.found    = 1'b1;
        res.position = mid[POS_W-1:0];
        return res;
      end
      if (code_mem[mid[ADDR_W-1:0]] > key) hi = mid - 1;
      else lo = mid + 1;
    end
    return res;
  endfunction

  always @(posedge clk) begin : watch
    search_result_t got;
    search_result_t want;
    if (rst) begin
      entry_count_q = '0;
      expected_hits.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        got.found    = rsp.found;
        got.position = rsp.position;
        if (expected_hits.size() == 0) begin
          report_mismatch($sformatf("result found=%b position=%0d with no search pending",
                                    got.found, got.position));
        end else begin
          want = expected_hits.pop_front();
          if (got.found !== want.found)
            report_mismatch($sformatf("found: expected %b, got %b", want.found, got.found));
          if (got.position !== want.position)
            report_mismatch($sformatf("position: expected %0d, got %0d",
                                      want.position, got.position));
        end
      end
      if (cfg_we) entry_count_q = cfg_wdata;
      if (req.valid && req.ready) begin
        if (req.func == stbs_pkg::FUNC_LOAD) code_mem[req.index] = req.value;
        else expected_hits.push_back(predict_search(req.value));
      end
    end
    mismatches  <= mismatch_count;
    outstanding <= expected_hits.size();
  end

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// Sorted table binary search testbench
// Loads sorted code tables of many sizes, writes the entry count between
// phases and issues searches for present, neighboring, extreme and random
// keys, with bursty request traffic and a stalling response side.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH;
  localparam int ADDR_W      = stbs_pkg::ADDR_W;
  localparam int FUNC_W      = stbs_pkg::FUNC_W;
  localparam int INDEX_W     = stbs_pkg::INDEX_W;
  localparam int VALUE_W     = stbs_pkg::VALUE_W;
  localparam int COUNT_W     = stbs_pkg::COUNT_W;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 7;
  localparam int ITEM_TARGET    = 940;
  // Let the block fall idle before a write.
  localparam int DRAIN_CYCLES   = 16;
  // Longest legal quiet stretch is a sender gap plus a search plus a sink stall.
  localparam int WATCHDOG_LIMIT = 2000;

  localparam logic signed [VALUE_W-1:0] CODE_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] CODE_MAX = 32'sh7fff_ffff;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [COUNT_W-1:0] cfg_wdata;
  int                 mismatches;
  int                 outstanding;

  stbs_req_if req ();
  stbs_rsp_if rsp ();

  sorted_table_binary_search i_dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  search_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .rsp         (rsp),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Stimulus bookkeeping: what has been loaded, used only to choose keys.
  // --------------------------------------------------------------------------
  logic signed [VALUE_W-1:0] shadow_code [TABLE_DEPTH];
  int burst_left  = 0;
  int items_sent  = 0;
  int quiet_cycles = 0;

  // Send one item. Between bursts drop valid for a random gap; inside a burst
  // hold valid high and just swap the payload, so valid never toggles twice
  // in one step.
  task automatic put_item(input logic [FUNC_W-1:0] f, input logic [INDEX_W-1:0] idx,
                          input logic signed [VALUE_W-1:0] val);
    int gap;
    if (burst_left == 0) begin
      req.valid <= 1'b0;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 4);
      repeat (gap) @(posedge clk);
      // Now and then a long burst with no idling at all.
      burst_left = ($urandom_range(0, 6) == 0) ? $urandom_range(40, 100)
                                                : $urandom_range(1, 12);
    end
    req.valid <= 1'b1;
    req.func  <= f;
    req.index <= idx;
    req.value <= val;
    do @(posedge clk); while (!req.ready);
    burst_left--;
    items_sent++;
    if (f == stbs_pkg::FUNC_LOAD) shadow_code[idx] = val;
  endtask

  // Drop valid, wait until every expected result has come back, then give
  // the block time to finish any load still in flight.
  task automatic settle();
    req.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write the entry count only once the block is idle.
  task automatic write_entry_count(input logic [COUNT_W-1:0] n);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= n;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Fill entries 0..n-1 with ascending codes: duplicates, tight steps and
  // wide steps, spread so the run of codes roughly spans the signed range.
  // About one fill in ten is plain random to exercise unsorted tables.
  task automatic load_sorted(input int n);
    longint code;
    longint span;
    bit     scramble;
    int     pick;
    span     = 64'd4294967295 / (n + 1);
    scramble = ($urandom_range(0, 9) == 0);
    code     = -64'sd2147483648;
    if ($urandom_range(0, 3) != 0) code = code + longint'($urandom_range(0, 32'(span)));
    for (int i = 0; i < n; i++) begin
      if (scramble) begin
        code = longint'($signed($urandom));
      end else if (i > 0) begin
        pick = $urandom_range(0, 99);
        if (pick < 15) code = code;
        else if (pick < 60) code = code + $urandom_range(1, 8);
        else code = code + longint'($urandom_range(1, 32'(span)));
        if (code > 64'sd2147483647) code = 64'sd2147483647;
      end
      put_item(stbs_pkg::FUNC_LOAD, INDEX_W'(i), code[VALUE_W-1:0]);
    end
  endtask

  // Pick a search key: mostly codes in the active prefix, then their near
  // misses, the extremes, and fully random keys.
  function automatic logic signed [VALUE_W-1:0] pick_key(input int n);
    int                        r;
    logic signed [VALUE_W-1:0] k;
    r = $urandom_range(0, 99);
    if (n > 0 && r < 55) return shadow_code[ADDR_W'($urandom_range(0, n - 1))];
    if (n > 0 && r < 75) begin
      k = shadow_code[ADDR_W'($urandom_range(0, n - 1))];
      return $urandom_range(0, 1) ? k + 1 : k - 1;
    end
    if (r < 85) begin
      case ($urandom_range(0, 3))
        0:       return CODE_MIN;
        1:       return CODE_MAX;
        2:       return '0;
        default: return -1;
      endcase
    end
    return $urandom;
  endfunction

  // Searches over an active prefix of n entries, mixed with stray loads
  // beyond the prefix and the odd load that breaks the ordering inside it.
  task automatic run_searches(input int n, input int count);
    int r;
    for (int j = 0; j < count; j++) begin
      r = $urandom_range(0, 99);
      if (r < 8 && n < TABLE_DEPTH)
        put_item(stbs_pkg::FUNC_LOAD, INDEX_W'($urandom_range(n, TABLE_DEPTH - 1)),
                 $urandom);
      else if (r < 11 && n > 0)
        put_item(stbs_pkg::FUNC_LOAD, INDEX_W'($urandom_range(0, n - 1)), $urandom);
      else
        put_item(stbs_pkg::FUNC_SEARCH, INDEX_W'($urandom_range(0, TABLE_DEPTH - 1)),
                 pick_key(n));
    end
  endtask

  // --------------------------------------------------------------------------
  // Response side: stall on a pattern that changes mode every so often:
  // always ready, ready at random (60 of 100), or a periodic stall window.
  // --------------------------------------------------------------------------
  int sink_mode   = 0;
  int sink_left   = 0;
  int sink_period = 4;
  int sink_stall  = 1;
  int sink_beat   = 0;

  always @(posedge clk) begin
    if (sink_left == 0) begin
      sink_mode   = $urandom_range(0, 2);
      sink_left   = $urandom_range(32, 256);
      sink_period = $urandom_range(4, 16);
      sink_stall  = $urandom_range(1, sink_period - 1);
      sink_beat   = 0;
    end
    sink_left--;
    sink_beat++;
    case (sink_mode)
      0:       rsp.ready <= 1'b1;
      1:       rsp.ready <= ($urandom_range(0, 99) < 60);
      default: rsp.ready <= ((sink_beat % sink_period) >= sink_stall);
    endcase
  end

  // Watchdog: end the run if nothing moves on either channel for too long.
  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("sorted_table_binary_search test failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int n;
    int r;
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    req.valid <= 1'b0;
    req.func  <= stbs_pkg::FUNC_LOAD;
    req.index <= '0;
    req.value <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Empty table: nothing can be found and no entry is probed.
    write_entry_count('0);
    put_item(stbs_pkg::FUNC_SEARCH, '0, '0);
    put_item(stbs_pkg::FUNC_SEARCH, '1, CODE_MAX);

    // Single entry holding the most negative code.
    write_entry_count(COUNT_W'(1));
    put_item(stbs_pkg::FUNC_LOAD, '0, CODE_MIN);
    put_item(stbs_pkg::FUNC_SEARCH, '0, CODE_MIN);
    put_item(stbs_pkg::FUNC_SEARCH, '0, CODE_MAX);
    put_item(stbs_pkg::FUNC_SEARCH, '0, '0);

    // Four entries spanning both extremes: hits at every probe depth, a miss
    // between codes.
    write_entry_count(COUNT_W'(4));
    put_item(stbs_pkg::FUNC_LOAD, INDEX_W'(1), -1);
    put_item(stbs_pkg::FUNC_LOAD, INDEX_W'(2), '0);
    put_item(stbs_pkg::FUNC_LOAD, INDEX_W'(3), CODE_MAX);
    put_item(stbs_pkg::FUNC_SEARCH, '0, -1);
    put_item(stbs_pkg::FUNC_SEARCH, '0, '0);
    put_item(stbs_pkg::FUNC_SEARCH, '0, CODE_MAX);
    put_item(stbs_pkg::FUNC_SEARCH, '0, 1);
    put_item(stbs_pkg::FUNC_SEARCH, '0, CODE_MIN);

    // Duplicates: the first probed match wins.
    write_entry_count(COUNT_W'(3));
    put_item(stbs_pkg::FUNC_LOAD, INDEX_W'(0), 5);
    put_item(stbs_pkg::FUNC_LOAD, INDEX_W'(1), 5);
    put_item(stbs_pkg::FUNC_LOAD, INDEX_W'(2), 5);
    put_item(stbs_pkg::FUNC_SEARCH, '0, 5);
    put_item(stbs_pkg::FUNC_SEARCH, '0, 4);

    // Top index of the table.
    put_item(stbs_pkg::FUNC_LOAD, '1, CODE_MAX);

    // Full table, then counts above the depth that saturate to it. These come
    // first so that the whole table stays written for them.
    write_entry_count(COUNT_W'(TABLE_DEPTH));
    load_sorted(TABLE_DEPTH);
    run_searches(TABLE_DEPTH, 40);
    write_entry_count(COUNT_W'($urandom_range(TABLE_DEPTH + 1, 1022)));
    run_searches(TABLE_DEPTH, 30);
    write_entry_count('1);
    run_searches(TABLE_DEPTH, 10);

    // Mostly small tables, reloaded each phase.
    while (items_sent < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 8) n = 0;
      else if (r < 16) n = 1;
      else if (r < 22) n = 2;
      else if (r < 92) n = $urandom_range(3, 32);
      else n = $urandom_range(33, 96);
      write_entry_count(COUNT_W'(n));
      load_sorted(n);
      run_searches(n, $urandom_range(3, 16));
    end

    settle();
    if (mismatches == 0) begin
      $display("sorted_table_binary_search test passed");
    end else begin
      $display("sorted_table_binary_search test failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/stbs_pkg.sv
sv/stbs_req_if.sv
sv/stbs_rsp_if.sv
sv/stbs_table.sv
sv/sorted_table_binary_search.sv
dv/search_checker.sv
dv/tb.sv
